[sv/assert_macros.svh]
// Assertion macros used by the expander top module.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PBPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define PBPE_ASSERT_IMPL(label, cond, concl, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (concl)) \
    else $error(msg);

`endif

[sv/pbpe_pkg.sv]
// Types and constants of the palette bitmap pixel expander.
// Used by the front, queue, back and top modules; depends on nothing.
package pbpe_pkg;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned DataWidth  = 32;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;
  localparam logic [7:0]  AlphaClear  = 8'h00;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_PIXEL   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH      = 3'd0,
    REG_IMAGE_HEIGHT     = 3'd1,
    REG_FOUR_BIT_MODE    = 3'd2,
    REG_TRANSPARENT_ZERO = 3'd3,
    REG_BOTTOM_UP        = 3'd4,
    REG_PALETTE_COUNT    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        four_bit_mode;
    logic        transparent_zero;
    logic        bottom_up;
    logic [8:0]  palette_count;
  } cfg_t;

  // One classified item: a palette write or a byte of one or two pixels.
  typedef struct packed {
    cmd_e        op;
    logic [7:0]  idx0;
    logic [7:0]  idx1;
    logic [23:0] color;
    logic        pair;
    logic [11:0] x;
    logic [11:0] y;
    logic        img_end;
  } job_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] x;
    logic [11:0] y;
    logic        run_end;
    logic        img_end;
  } pix_t;

endpackage

[sv/pbpe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package use.
module pbpe_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pbpe_front.sv]
// Front end: accepts input beats, tracks row and column, classifies bytes.
// Uses pbpe_pkg types; feeds pbpe_queue.
module pbpe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pbpe_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [7:0]        entry_index_i,
  input  logic [7:0]        entry_blue_i,
  input  logic [7:0]        entry_green_i,
  input  logic [7:0]        entry_red_i,
  input  logic [7:0]        pixel_byte_i,
  output logic              job_valid_o,
  output pbpe_pkg::job_t    job_o,
  input  logic              job_ready_i
);

  logic [12:0] col_q, col_d;
  logic [11:0] row_q, row_d;
  logic        done_q, done_d;

  logic [12:0] w_eff, h_eff, w_inc, line_bytes, pad_sum, padded;
  logic [12:0] row_ext, h_last, col_inc;
  logic [13:0] x_ext, w_ext, x_end;
  logic [11:0] y;
  logic        row_live, last_row, col_live, pair, img_end, accept, is_pixel;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      w_eff = 13'd1;
    end else if (cfg_i.image_width > 13'(pbpe_pkg::MaxWidth)) begin
      w_eff = 13'(pbpe_pkg::MaxWidth);
    end else begin
      w_eff = cfg_i.image_width;
    end
    if (cfg_i.image_height == '0) begin
      h_eff = 13'd1;
    end else if (cfg_i.image_height > 13'(pbpe_pkg::MaxHeight)) begin
      h_eff = 13'(pbpe_pkg::MaxHeight);
    end else begin
      h_eff = cfg_i.image_height;
    end
  end

  assign w_inc      = w_eff + 13'd1;
  assign line_bytes = cfg_i.four_bit_mode ? {1'b0, w_inc[12:1]} : w_eff;
  assign pad_sum    = line_bytes + 13'd3;
  assign padded     = {pad_sum[12:2], 2'b00};
  assign row_ext    = {1'b0, row_q};
  assign h_last     = h_eff - 13'd1;
  assign row_live   = row_ext < h_eff;
  assign last_row   = row_ext == h_last;
  assign y          = cfg_i.bottom_up ? 12'(h_last - row_ext) : row_q;
  assign col_live   = col_q < line_bytes;
  assign col_inc    = col_q + 13'd1;
  assign x_ext      = cfg_i.four_bit_mode ? {col_q, 1'b0} : {1'b0, col_q};
  assign w_ext      = {1'b0, w_eff};
  assign pair       = cfg_i.four_bit_mode && ((x_ext + 14'd1) < w_ext);
  assign x_end      = x_ext + (pair ? 14'd2 : 14'd1);
  assign img_end    = last_row && (x_end == w_ext);

  assign is_pixel   = pbpe_pkg::cmd_e'(cmd_i) == pbpe_pkg::CMD_PIXEL;
  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && job_ready_i;

  assign job_valid_o = in_valid_i && (!is_pixel || (!done_q && row_live && col_live));

  always_comb begin
    job_o.op      = pbpe_pkg::cmd_e'(cmd_i);
    job_o.idx0    = is_pixel ? (cfg_i.four_bit_mode ? {4'b0, pixel_byte_i[7:4]} : pixel_byte_i)
                             : entry_index_i;
    job_o.idx1    = {4'b0, pixel_byte_i[3:0]};
    job_o.color   = {entry_red_i, entry_green_i, entry_blue_i};
    job_o.pair    = pair;
    job_o.x       = x_ext[11:0];
    job_o.y       = y;
    job_o.img_end = img_end;
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    done_d = done_q;
    if (accept && is_pixel && !done_q) begin
      if (!row_live) begin
        done_d = 1'b1;
      end else if (col_inc >= padded) begin
        col_d = '0;
        row_d = row_q + 12'd1;
        if ((row_ext + 13'd1) >= h_eff) begin
          done_d = 1'b1;
        end
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      done_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      done_q <= done_d;
    end
  end

endmodule

[sv/pbpe_queue.sv]
// Two-entry job queue between front and back end.
// Uses pbpe_pkg::job_t.
module pbpe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  pbpe_pkg::job_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output pbpe_pkg::job_t  pop_data_o
);

  localparam int unsigned Depth = 2;

  pbpe_pkg::job_t entries_q [Depth];
  logic           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  assign push_ready_o = cnt_q != 2'(Depth);
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[sv/pbpe_back.sv]
// Back end: palette writes, color lookup per pixel and the result buffer.
// Uses pbpe_pkg types and one pbpe_ram for the palette.
module pbpe_back #(
  parameter int unsigned PaletteEntries = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pbpe_pkg::cfg_t  cfg_i,
  input  logic            job_valid_i,
  input  pbpe_pkg::job_t  job_i,
  output logic            job_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pbpe_pkg::pix_t  pix_o
);

  localparam int unsigned AddrW    = $clog2(PaletteEntries);
  localparam int unsigned OutDepth = 4;

  logic        sub_q, sub_d;
  logic [23:0] entry0_q;
  logic        is_pix, wr, issue, last_sub, credit_ok, wr_in_range;
  logic [7:0]  rd_idx;
  logic [23:0] rdata;

  logic        b_valid_q;
  logic [7:0]  b_idx_q;
  logic [11:0] b_x_q, b_y_q;
  logic        b_run_end_q, b_img_end_q;
  logic        b_in_range, b_dup;
  logic [23:0] b_color;
  pbpe_pkg::pix_t b_pix;

  pbpe_pkg::pix_t ofifo_q [OutDepth];
  logic [1:0]  owr_q, ord_q;
  logic [2:0]  ocnt_q, ocnt_d;
  logic        opop;

  assign is_pix      = job_i.op == pbpe_pkg::CMD_PIXEL;
  assign credit_ok   = (ocnt_q + {2'b0, b_valid_q}) < 3'(OutDepth);
  assign wr          = job_valid_i && !is_pix;
  assign issue       = job_valid_i && is_pix && credit_ok;
  assign last_sub    = !job_i.pair || sub_q;
  assign job_ready_o = wr || (issue && last_sub);
  assign wr_in_range = {1'b0, job_i.idx0} < 9'(PaletteEntries);
  assign rd_idx      = sub_q ? job_i.idx1 : job_i.idx0;
  assign sub_d       = issue ? !last_sub : sub_q;

  pbpe_ram #(
    .Width (24),
    .Depth (PaletteEntries)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (wr && wr_in_range),
    .waddr_i (job_i.idx0[AddrW-1:0]),
    .wdata_i (job_i.color),
    .re_i    (issue),
    .raddr_i (rd_idx[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (wr && job_i.idx0 == 8'd0) begin
      entry0_q <= job_i.color;
    end
    if (issue) begin
      b_idx_q     <= rd_idx;
      b_x_q       <= job_i.x + {11'b0, sub_q};
      b_y_q       <= job_i.y;
      b_run_end_q <= last_sub;
      b_img_end_q <= last_sub && job_i.img_end;
    end
  end

  assign b_in_range = {1'b0, b_idx_q} < 9'(PaletteEntries);
  assign b_color    = b_in_range ? rdata : 24'd0;
  assign b_dup      = b_in_range && (b_idx_q != 8'd0)
                   && ({1'b0, b_idx_q} < cfg_i.palette_count) && (b_color == entry0_q);

  always_comb begin
    b_pix.red     = b_color[23:16];
    b_pix.green   = b_color[15:8];
    b_pix.blue    = {b_color[7:1], b_color[0] ^ b_dup};
    b_pix.alpha   = (cfg_i.transparent_zero && b_idx_q == 8'd0) ? pbpe_pkg::AlphaClear
                                                                 : pbpe_pkg::AlphaOpaque;
    b_pix.x       = b_x_q;
    b_pix.y       = b_y_q;
    b_pix.run_end = b_run_end_q;
    b_pix.img_end = b_img_end_q;
  end

  assign out_valid_o = ocnt_q != 3'd0;
  assign pix_o       = ofifo_q[ord_q];
  assign opop        = out_valid_o && out_ready_i;
  assign ocnt_d      = ocnt_q + {2'b0, b_valid_q} - {2'b0, opop};

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      ofifo_q[owr_q] <= b_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q     <= 1'b0;
      b_valid_q <= 1'b0;
      owr_q     <= '0;
      ord_q     <= '0;
      ocnt_q    <= '0;
    end else begin
      sub_q     <= sub_d;
      b_valid_q <= issue;
      owr_q     <= owr_q + {1'b0, b_valid_q};
      ord_q     <= ord_q + {1'b0, opop};
      ocnt_q    <= ocnt_d;
    end
  end

endmodule

[sv/palette_bmp_pixel_expander_top.sv]
// channel  handshake                 payload
// in       in_valid_i / in_ready_o   cmd, entry_index, entry_blue/green/red, pixel_byte
// out      out_valid_o / out_ready_i red, green, blue, alpha, pixel_x, pixel_y, last_of_*
// cfg      psel, penable, pwrite     paddr, pwdata, prdata, pready (always high)
//
// An input beat is taken every cycle while the two-entry job queue has room.
// The palette RAM has one read port: an 8-bit byte costs one lookup, a two-pixel
// 4-bit byte two; pixels leave at one per cycle while the output buffer has room.
// A byte passes job queue, RAM read register and output buffer to its first pixel;
// output stalls back up into the queue, then in_ready_o. Reset needs no clearing.
// Holds the configuration registers; depends on pbpe_pkg and the pbpe modules.
`include "assert_macros.svh"

module palette_bmp_pixel_expander_top #(
  parameter int unsigned PaletteEntries = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pbpe_pkg::AddrWidth-1:0]    paddr,
  input  logic [pbpe_pkg::DataWidth-1:0]    pwdata,
  output logic [pbpe_pkg::DataWidth-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [7:0]                        entry_index_i,
  input  logic [7:0]                        entry_blue_i,
  input  logic [7:0]                        entry_green_i,
  input  logic [7:0]                        entry_red_i,
  input  logic [7:0]                        pixel_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        red_o,
  output logic [7:0]                        green_o,
  output logic [7:0]                        blue_o,
  output logic [7:0]                        alpha_o,
  output logic [11:0]                       pixel_x_o,
  output logic [11:0]                       pixel_y_o,
  output logic                              last_of_run_o,
  output logic                              last_of_image_o
);

  pbpe_pkg::cfg_t     cfg_q, cfg_d;
  pbpe_pkg::reg_idx_e reg_idx;
  logic               cfg_wr;

  logic               f_valid, f_ready, q_valid, q_ready;
  pbpe_pkg::job_t     f_job, q_job;
  pbpe_pkg::pix_t     pix;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = pbpe_pkg::reg_idx_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        pbpe_pkg::REG_IMAGE_WIDTH:      cfg_d.image_width      = pwdata[12:0];
        pbpe_pkg::REG_IMAGE_HEIGHT:     cfg_d.image_height     = pwdata[12:0];
        pbpe_pkg::REG_FOUR_BIT_MODE:    cfg_d.four_bit_mode    = pwdata[0];
        pbpe_pkg::REG_TRANSPARENT_ZERO: cfg_d.transparent_zero = pwdata[0];
        pbpe_pkg::REG_BOTTOM_UP:        cfg_d.bottom_up        = pwdata[0];
        pbpe_pkg::REG_PALETTE_COUNT:    cfg_d.palette_count    = pwdata[8:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pbpe_pkg::REG_IMAGE_WIDTH:      prdata = {19'b0, cfg_q.image_width};
      pbpe_pkg::REG_IMAGE_HEIGHT:     prdata = {19'b0, cfg_q.image_height};
      pbpe_pkg::REG_FOUR_BIT_MODE:    prdata = {31'b0, cfg_q.four_bit_mode};
      pbpe_pkg::REG_TRANSPARENT_ZERO: prdata = {31'b0, cfg_q.transparent_zero};
      pbpe_pkg::REG_BOTTOM_UP:        prdata = {31'b0, cfg_q.bottom_up};
      pbpe_pkg::REG_PALETTE_COUNT:    prdata = {23'b0, cfg_q.palette_count};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width      <= 13'd1;
      cfg_q.image_height     <= 13'd1;
      cfg_q.four_bit_mode    <= 1'b0;
      cfg_q.transparent_zero <= 1'b0;
      cfg_q.bottom_up        <= 1'b1;
      cfg_q.palette_count    <= 9'd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pbpe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .entry_blue_i  (entry_blue_i),
    .entry_green_i (entry_green_i),
    .entry_red_i   (entry_red_i),
    .pixel_byte_i  (pixel_byte_i),
    .job_valid_o   (f_valid),
    .job_o         (f_job),
    .job_ready_i   (f_ready)
  );

  pbpe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  pbpe_back #(
    .PaletteEntries (PaletteEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_ready_o (q_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pix_o       (pix)
  );

  assign red_o           = pix.red;
  assign green_o         = pix.green;
  assign blue_o          = pix.blue;
  assign alpha_o         = pix.alpha;
  assign pixel_x_o       = pix.x;
  assign pixel_y_o       = pix.y;
  assign last_of_run_o   = pix.run_end;
  assign last_of_image_o = pix.img_end;

  `PBPE_ASSERT_IMPL(a_pair_even_col, q_valid && q_job.op == pbpe_pkg::CMD_PIXEL && q_job.pair, !q_job.x[0], "pixel pair starts at odd column")
  `PBPE_ASSERT_IMPL(a_img_end_run, out_valid_o && last_of_image_o, last_of_run_o, "image end without run end")
  `PBPE_ASSERT_IMPL(a_alpha_clear, out_valid_o && alpha_o != pbpe_pkg::AlphaOpaque, cfg_q.transparent_zero && alpha_o == pbpe_pkg::AlphaClear, "unexpected alpha")
  `PBPE_ASSERT(a_no_pop_empty, !(q_ready && !q_valid), "queue popped while empty")

endmodule

[test/tb.sv]
// Testbench for palette_bmp_pixel_expander_top: palette loads, 4/8-bit pixel rows,
// padding and row/image ends, checked against a scoreboard that predicts each pixel.
// Depends on pbpe_pkg and the expander RTL.
module tb;

  typedef struct packed {
    pbpe_pkg::cmd_e cmd;
    logic [7:0]     entry_idx;
    logic [7:0]     blue;
    logic [7:0]     green;
    logic [7:0]     red;
    logic [7:0]     pix_byte;
  } in_beat_t;

  class pixel_scoreboard;
    logic [23:0]    palette [256];
    logic [12:0]    width, height;
    logic           four_bit, transp, bottom_up;
    logic [8:0]     pal_count;
    int unsigned    byte_col, row;
    bit             done;
    pbpe_pkg::pix_t expected_q[$];
    int             errors;

    function new();
      width = 1; height = 1; four_bit = 0; transp = 0; bottom_up = 1; pal_count = 256;
      byte_col = 0; row = 0; done = 0; errors = 0;
    endfunction

    function void set_reg(pbpe_pkg::reg_idx_e r, logic [31:0] v);
      case (r)
        pbpe_pkg::REG_IMAGE_WIDTH:      width = v[12:0];
        pbpe_pkg::REG_IMAGE_HEIGHT:     height = v[12:0];
        pbpe_pkg::REG_FOUR_BIT_MODE:    four_bit = v[0];
        pbpe_pkg::REG_TRANSPARENT_ZERO: transp = v[0];
        pbpe_pkg::REG_BOTTOM_UP:        bottom_up = v[0];
        pbpe_pkg::REG_PALETTE_COUNT:    pal_count = v[8:0];
        default: ;
      endcase
    endfunction

    function pbpe_pkg::pix_t color_of(int unsigned idx, int unsigned x, int unsigned y,
                                      bit run_end, bit img_end);
      pbpe_pkg::pix_t p;
      logic [23:0]    c;
      c = palette[idx];
      if (idx != 0 && idx < pal_count && c == palette[0]) c[0] = ~c[0];
      p.red = c[23:16];
      p.green = c[15:8];
      p.blue = c[7:0];
      p.alpha = (transp && idx == 0) ? pbpe_pkg::AlphaClear : pbpe_pkg::AlphaOpaque;
      p.x = 12'(x);
      p.y = 12'(y);
      p.run_end = run_end;
      p.img_end = img_end;
      return p;
    endfunction

    function void note_input(in_beat_t b);
      int unsigned w, h, line_bytes, padded, y, x;
      bit          last_row;
      if (b.cmd == pbpe_pkg::CMD_PALETTE) begin
        palette[b.entry_idx] = {b.red, b.green, b.blue};
        return;
      end
      if (done) return;
      w = (width == 0) ? 1 : (width > pbpe_pkg::MaxWidth) ? pbpe_pkg::MaxWidth : width;
      h = (height == 0) ? 1 : (height > pbpe_pkg::MaxHeight) ? pbpe_pkg::MaxHeight : height;
      if (row >= h) begin
        done = 1;
        return;
      end
      line_bytes = four_bit ? (w + 1) / 2 : w;
      padded = ((line_bytes + 3) / 4) * 4;
      y = bottom_up ? h - 1 - row : row;
      last_row = (row == h - 1);
      if (byte_col < line_bytes) begin
        if (four_bit) begin
          x = byte_col * 2;
          if (x + 1 < w) begin
            expected_q.push_back(color_of(b.pix_byte[7:4], x, y, 0, 0));
            expected_q.push_back(color_of(b.pix_byte[3:0], x + 1, y, 1,
                                          last_row && x + 2 == w));
          end else begin
            expected_q.push_back(color_of(b.pix_byte[7:4], x, y, 1,
                                          last_row && x + 1 == w));
          end
        end else begin
          expected_q.push_back(color_of(b.pix_byte, byte_col, y, 1,
                                        last_row && byte_col + 1 == w));
        end
      end
      byte_col++;
      if (byte_col >= padded) begin
        byte_col = 0;
        row++;
        if (row >= h) done = 1;
      end
    endfunction

    function void cmp(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pbpe_pkg::pix_t got);
      pbpe_pkg::pix_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected pixel at x %0d y %0d", got.x, got.y);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp("red", want.red, got.red);
      cmp("green", want.green, got.green);
      cmp("blue", want.blue, got.blue);
      cmp("alpha", want.alpha, got.alpha);
      cmp("pixel_x", want.x, got.x);
      cmp("pixel_y", want.y, got.y);
      cmp("last_of_run", want.run_end, got.run_end);
      cmp("last_of_image", want.img_end, got.img_end);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                           clk_i, rst_ni;
  logic                           psel, penable, pwrite, pready;
  logic [pbpe_pkg::AddrWidth-1:0] paddr;
  logic [pbpe_pkg::DataWidth-1:0] pwdata, prdata;
  logic                           in_valid_i, in_ready_o, cmd_i;
  logic [7:0]                     entry_index_i, entry_blue_i, entry_green_i, entry_red_i;
  logic [7:0]                     pixel_byte_i;
  logic                           out_valid_o, out_ready_i;
  logic [7:0]                     red_o, green_o, blue_o, alpha_o;
  logic [11:0]                    pixel_x_o, pixel_y_o;
  logic                           last_of_run_o, last_of_image_o;

  bit              steady;
  pixel_scoreboard sb;

  palette_bmp_pixel_expander_top dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .cmd_i, .entry_index_i, .entry_blue_i, .entry_green_i,
    .entry_red_i, .pixel_byte_i, .out_valid_o, .out_ready_i, .red_o, .green_o, .blue_o,
    .alpha_o, .pixel_x_o, .pixel_y_o, .last_of_run_o, .last_of_image_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  function automatic in_beat_t make_pixel(logic [7:0] v);
    in_beat_t b;
    b.cmd = pbpe_pkg::CMD_PIXEL;
    b.entry_idx = 8'($urandom);
    b.blue = 8'($urandom);
    b.green = 8'($urandom);
    b.red = 8'($urandom);
    b.pix_byte = v;
    return b;
  endfunction

  function automatic in_beat_t make_entry(logic [7:0] i, logic [23:0] rgb);
    in_beat_t b;
    b.cmd = pbpe_pkg::CMD_PALETTE;
    b.entry_idx = i;
    {b.red, b.green, b.blue} = rgb;
    b.pix_byte = 8'($urandom);
    return b;
  endfunction

  task automatic send(input in_beat_t b);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= b.cmd;
    entry_index_i <= b.entry_idx;
    entry_blue_i <= b.blue;
    entry_green_i <= b.green;
    entry_red_i <= b.red;
    pixel_byte_i <= b.pix_byte;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(b);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input pbpe_pkg::reg_idx_e r, input logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(r, v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_config(input logic [12:0] w, input logic [12:0] h, input logic fb,
                              input logic tz, input logic bu, input logic [8:0] pc);
    write_reg(pbpe_pkg::REG_IMAGE_WIDTH, w);
    write_reg(pbpe_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(pbpe_pkg::REG_FOUR_BIT_MODE, fb);
    write_reg(pbpe_pkg::REG_TRANSPARENT_ZERO, tz);
    write_reg(pbpe_pkg::REG_BOTTOM_UP, bu);
    write_reg(pbpe_pkg::REG_PALETTE_COUNT, pc);
  endtask

  // Output side: sample at the rising edge, change ready at the falling edge.
  initial begin : pixel_sink
    pbpe_pkg::pix_t got;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.red = red_o;
        got.green = green_o;
        got.blue = blue_o;
        got.alpha = alpha_o;
        got.x = pixel_x_o;
        got.y = pixel_y_o;
        got.run_end = last_of_run_o;
        got.img_end = last_of_image_o;
        sb.check_pixel(got);
      end
      @(negedge clk_i);
      out_ready_i <= steady || ($urandom_range(0, 99) >= 22);
    end
  end

  initial begin : stimulus
    logic [23:0] zero_rgb, rgb;
    logic [12:0] w, h;
    logic [8:0]  pc;
    int unsigned rand_sent, n, phase_no, r;
    sb = new();
    steady = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    cmd_i = pbpe_pkg::CMD_PIXEL;
    entry_index_i = '0;
    entry_blue_i = '0;
    entry_green_i = '0;
    entry_red_i = '0;
    pixel_byte_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wide single-row image so heights zero and one can be tried without ending it.
    write_config(13'd4096, 13'd0, 1'b0, 1'b1, 1'b0, 9'd256);

    // Fill the whole palette, with copies of entry zero and near-copies.
    zero_rgb = 24'($urandom);
    for (int i = 0; i < 256; i++) begin
      case (i)
        0:       rgb = zero_rgb;
        1:       rgb = zero_rgb ^ 24'h1;
        2, 255:  rgb = zero_rgb;
        3:       rgb = 24'h000000;
        4:       rgb = 24'hFFFFFF;
        default: rgb = 24'($urandom);
      endcase
      send(make_entry(8'(i), rgb));
    end

    send(make_pixel(8'h00));
    send(make_pixel(8'hFF));
    send(make_pixel(8'h01));
    send(make_pixel(8'h02));
    send(make_pixel(8'h03));
    send(make_pixel(8'h04));
    send(make_pixel(8'h80));
    settle();
    write_reg(pbpe_pkg::REG_IMAGE_HEIGHT, 13'd1);
    write_reg(pbpe_pkg::REG_BOTTOM_UP, 1'b1);
    send(make_pixel(8'h7F));
    send(make_entry(8'hFF, 24'hFFFFFF));
    send(make_pixel(8'hFF));
    send(make_entry(8'h00, 24'h000000));
    send(make_pixel(8'h03));
    send(make_pixel(8'h00));

    // Odd width in 4-bit mode: one pixel from the last byte, then a padding byte.
    settle();
    write_config(13'd5, 13'd4096, 1'b1, 1'b0, 1'b1, 9'd0);
    send(make_pixel(8'h55));
    send(make_pixel(8'h0F));
    send(make_pixel(8'hF0));
    send(make_pixel(8'h12));
    send(make_pixel(8'h34));
    send(make_pixel(8'h30));

    rand_sent = 0;
    phase_no = 0;
    while (rand_sent < 640) begin
      settle();
      r = $urandom_range(0, 19);
      case (r)
        0:       w = 13'd0;
        1:       w = 13'd4096;
        2:       w = 13'($urandom_range(4097, 8191));
        3:       w = 13'd8191;
        4:       w = 13'($urandom_range(41, 4095));
        default: w = 13'($urandom_range(1, 40));
      endcase
      r = $urandom_range(0, 3);
      case (r)
        0:       h = 13'd4096;
        1:       h = 13'd8191;
        2:       h = 13'($urandom_range(4097, 8191));
        default: h = 13'($urandom_range(1000, 4095));
      endcase
      r = $urandom_range(0, 9);
      case (r)
        0:       pc = 9'd0;
        1:       pc = 9'd256;
        2:       pc = 9'd511;
        3:       pc = 9'($urandom_range(257, 511));
        default: pc = 9'($urandom_range(0, 256));
      endcase
      write_config(w, h, 1'($urandom), 1'($urandom), 1'($urandom), pc);
      steady = (phase_no == 4);
      n = steady ? 150 : $urandom_range(20, 70);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 85) send(make_pixel(8'($urandom)));
        else if (r < 90) send(make_entry(8'($urandom), sb.palette[0]));
        else if (r < 92) send(make_entry(8'h00, 24'($urandom)));
        else send(make_entry(8'($urandom), 24'($urandom)));
      end
      steady = 1'b0;
      rand_sent += n;
      phase_no++;
    end

    // Close the image two rows on, then feed bytes past its end.
    settle();
    write_config(13'($urandom_range(1, 9)), 13'(sb.row + 2), 1'($urandom), 1'($urandom),
                 1'($urandom), 9'd256);
    while (!sb.done) send(make_pixel(8'($urandom)));
    repeat (8) send(make_pixel(8'($urandom)));
    send(make_entry(8'($urandom), 24'($urandom)));
    send(make_pixel(8'($urandom)));

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[palette_bmp_pixel_expander_top.f]
+incdir+sv
sv/pbpe_pkg.sv
sv/pbpe_ram.sv
sv/pbpe_front.sv
sv/pbpe_queue.sv
sv/pbpe_back.sv
sv/palette_bmp_pixel_expander_top.sv
test/tb.sv
